// File: rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types, sizes, codes and the cell address function for the activity
// time accumulator.
// ----------------------------------------------------------------------------
package ata_pkg;

    // Table geometry: feature rows, each with one column per procedure
    // plus one column for the feature total.
    localparam int FEATURES   = 8;
    localparam int PROCEDURES = 8;
    localparam int COLS       = PROCEDURES + 1;
    localparam int CELLS      = FEATURES * COLS;
    localparam int CELL_W     = $clog2(CELLS);

    // Field widths.
    localparam int MODE_W   = 3;
    localparam int FEAT_W   = 4;
    localparam int PROC_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [CELL_W-1:0]   cell_addr_t;
    typedef logic [STAMP_W-1:0]  stamp_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request modes.
    localparam mode_t MODE_BOOT_START = 3'd0;
    localparam mode_t MODE_BOOT_STOP  = 3'd1;
    localparam mode_t MODE_FEAT_START = 3'd2;
    localparam mode_t MODE_FEAT_STOP  = 3'd3;
    localparam mode_t MODE_PROC_START = 3'd4;
    localparam mode_t MODE_PROC_STOP  = 3'd5;
    localparam mode_t MODE_READ_CELL  = 3'd6;
    localparam mode_t MODE_READ_BOOT  = 3'd7;

    // Response status codes.
    localparam status_t STATUS_DONE     = 2'd0;
    localparam status_t STATUS_INACTIVE = 2'd1;
    localparam status_t STATUS_MISMATCH = 2'd2;
    localparam status_t STATUS_RANGE    = 2'd3;

    // Table operation carried from decode to the write-back cycle.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_STAMP,
        OP_ACCUM,
        OP_READ
    } op_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        mode_t                mode;
        logic [FEAT_W-1:0]    feature_id;
        logic [PROC_W-1:0]    procedure_id;
        stamp_t               timestamp;
    } req_t;

    typedef struct packed {
        stamp_t  read_value;
        status_t status;
        logic    suspended;
    } rsp_t;

    // Access to the two cell tables; both share one address.
    typedef struct packed {
        logic       rd_en;
        logic       stamp_we;
        logic       accum_we;
        cell_addr_t addr;
        stamp_t     stamp_wdata;
        stamp_t     accum_wdata;
    } cell_port_t;

    // Flat cell index of (feature, procedure); feature counts from one.
    function automatic cell_addr_t cell_index(input logic [FEAT_W-1:0] feat,
                                              input logic [PROC_W-1:0] proc);
        int idx;
        idx = (int'(feat) - 1) * COLS + int'(proc);
        return cell_addr_t'(idx);
    endfunction

endpackage

// File: rtl/ata_cell_ram.sv
// ----------------------------------------------------------------------------
// ata_cell_ram
// One cell table: single port synchronous memory with registered read data
// and per-entry valid bits, so that entries read as zero until written.
// ----------------------------------------------------------------------------
module ata_cell_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic                we,
    input  ata_pkg::cell_addr_t addr,
    input  ata_pkg::stamp_t     wdata,
    output ata_pkg::stamp_t     rdata
);

    ata_pkg::stamp_t                 mem_reg [ata_pkg::CELLS];
    logic [ata_pkg::CELLS-1:0]       valid_reg;
    ata_pkg::stamp_t                 rd_data_reg;
    logic                            rd_valid_reg;

    // Storage array and read data register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    // Valid bits, cleared at once by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    // An entry never written reads as zero.
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/ata_seq.sv
// ----------------------------------------------------------------------------
// ata_seq
// Request decoder and sequencer: updates the boot and feature registers,
// issues the table read, and performs the read-modify-write of a cell.
// ----------------------------------------------------------------------------
module ata_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  ata_pkg::req_t         req_data,
    output logic                  req_stall,
    input  logic                  out_free,
    output ata_pkg::cell_port_t   cell_port,
    input  ata_pkg::stamp_t       stamp_rdata,
    input  ata_pkg::stamp_t       accum_rdata,
    output logic                  rsp_load,
    output ata_pkg::rsp_t         rsp_next,
    output logic                  suspended
);

    ata_pkg::state_t              state_reg, state_next;
    logic                         accept;

    ata_pkg::stamp_t              boot_start_reg, boot_start_next;
    ata_pkg::stamp_t              boot_total_reg, boot_total_next;
    logic [ata_pkg::FEAT_W-1:0]   open_reg, open_next;
    logic                         susp_reg, susp_next;

    ata_pkg::op_t                 op_reg, op_next;
    ata_pkg::cell_addr_t          addr_reg, addr_next;
    ata_pkg::stamp_t              ts_reg;
    ata_pkg::status_t             status_reg, status_next;
    ata_pkg::stamp_t              value_reg, value_next;

    logic                         measuring;
    logic                         feat_ok;
    logic                         finish;

    assign accept    = req_valid && (state_reg == ata_pkg::ST_IDLE);
    assign finish    = (state_reg == ata_pkg::ST_EXEC) && out_free;
    assign measuring = !susp_reg && (open_reg != '0);
    assign feat_ok   = (req_data.feature_id != '0) &&
                       (req_data.feature_id <= ata_pkg::FEAT_W'(ata_pkg::FEATURES));

    // Decode of one request against the current control registers.
    always_comb
    begin
        boot_start_next = boot_start_reg;
        boot_total_next = boot_total_reg;
        open_next       = open_reg;
        susp_next       = susp_reg;
        op_next         = ata_pkg::OP_NONE;
        status_next     = ata_pkg::STATUS_DONE;
        value_next      = '0;
        addr_next       = ata_pkg::cell_index(req_data.feature_id, req_data.procedure_id);
        case (req_data.mode)
            ata_pkg::MODE_BOOT_START:
            begin
                boot_start_next = req_data.timestamp;
            end
            ata_pkg::MODE_BOOT_STOP:
            begin
                boot_total_next = req_data.timestamp - boot_start_reg;
                susp_next       = 1'b1;
                open_next       = '0;
            end
            ata_pkg::MODE_FEAT_START:
            begin
                if (susp_reg)
                begin
                    status_next = ata_pkg::STATUS_INACTIVE;
                end
                else if (!feat_ok)
                begin
                    status_next = ata_pkg::STATUS_RANGE;
                end
                else
                begin
                    open_next = req_data.feature_id;
                    op_next   = ata_pkg::OP_STAMP;
                    addr_next = ata_pkg::cell_index(req_data.feature_id,
                                                    ata_pkg::PROC_W'(ata_pkg::PROCEDURES));
                end
            end
            ata_pkg::MODE_FEAT_STOP:
            begin
                if (!measuring)
                begin
                    status_next = ata_pkg::STATUS_INACTIVE;
                end
                else
                begin
                    op_next   = ata_pkg::OP_ACCUM;
                    addr_next = ata_pkg::cell_index(open_reg,
                                                    ata_pkg::PROC_W'(ata_pkg::PROCEDURES));
                    open_next = '0;
                    if (req_data.feature_id != open_reg)
                    begin
                        status_next = ata_pkg::STATUS_MISMATCH;
                    end
                end
            end
            ata_pkg::MODE_PROC_START, ata_pkg::MODE_PROC_STOP:
            begin
                if (!measuring)
                begin
                    status_next = ata_pkg::STATUS_INACTIVE;
                end
                else if (req_data.procedure_id >= ata_pkg::PROC_W'(ata_pkg::PROCEDURES))
                begin
                    status_next = ata_pkg::STATUS_RANGE;
                end
                else
                begin
                    addr_next = ata_pkg::cell_index(open_reg, req_data.procedure_id);
                    op_next   = (req_data.mode == ata_pkg::MODE_PROC_START) ?
                                ata_pkg::OP_STAMP : ata_pkg::OP_ACCUM;
                end
            end
            ata_pkg::MODE_READ_CELL:
            begin
                if (!feat_ok ||
                    (req_data.procedure_id > ata_pkg::PROC_W'(ata_pkg::PROCEDURES)))
                begin
                    status_next = ata_pkg::STATUS_RANGE;
                end
                else
                begin
                    op_next = ata_pkg::OP_READ;
                end
            end
            default:
            begin
                value_next = boot_total_reg;
            end
        endcase
    end

    // Control registers and the context of the request in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ata_pkg::ST_IDLE;
            boot_start_reg <= '0;
            boot_total_reg <= '0;
            open_reg       <= '0;
            susp_reg       <= 1'b0;
            op_reg         <= ata_pkg::OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                boot_start_reg <= boot_start_next;
                boot_total_reg <= boot_total_next;
                open_reg       <= open_next;
                susp_reg       <= susp_next;
                op_reg         <= op_next;
            end
        end
    end

    // Payload of the request in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= addr_next;
            ts_reg     <= req_data.timestamp;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ata_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ata_pkg::ST_EXEC;
                end
            end
            ata_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ata_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ata_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, table access and response load.
    always_comb
    begin
        req_stall             = 1'b1;
        rsp_load              = 1'b0;
        cell_port.rd_en       = 1'b0;
        cell_port.stamp_we    = 1'b0;
        cell_port.accum_we    = 1'b0;
        cell_port.addr        = addr_reg;
        // Write data: a stop adds the elapsed time, wrapping modulo 2^32.
        cell_port.stamp_wdata = ts_reg;
        cell_port.accum_wdata = accum_rdata + (ts_reg - stamp_rdata);
        case (state_reg)
            ata_pkg::ST_IDLE:
            begin
                req_stall       = 1'b0;
                cell_port.addr  = addr_next;
                cell_port.rd_en = accept && ((op_next == ata_pkg::OP_ACCUM) ||
                                             (op_next == ata_pkg::OP_READ));
            end
            ata_pkg::ST_EXEC:
            begin
                rsp_load           = finish;
                cell_port.stamp_we = finish && (op_reg == ata_pkg::OP_STAMP);
                cell_port.accum_we = finish && (op_reg == ata_pkg::OP_ACCUM);
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Response of the request in flight.
    assign rsp_next.read_value = (op_reg == ata_pkg::OP_READ) ? accum_rdata : value_reg;
    assign rsp_next.status     = status_reg;
    assign rsp_next.suspended  = susp_reg;
    assign suspended           = susp_reg;

endmodule

// File: rtl/activity_time_accumulator_core.sv
// ----------------------------------------------------------------------------
// activity_time_accumulator_core
// Profiling unit that accumulates boot, feature and procedure times from
// timestamped event requests into a feature by procedure table.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, where the cell address is decoded and,
// for a stop or a read, the start stamp and accumulated time tables are read. In
// the execute state, once the output register is free, the cell is updated and
// written back while the response is loaded into the output register. The
// sequencer then returns to idle and can accept a new request, also while the
// previous response still waits in the output register; it takes no new request
// before the last one is through. Both tables are cleared at reset through
// per-entry valid bits, so it is ready right after reset with no clearing pass.
module activity_time_accumulator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ata_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ata_pkg::rsp_t  rsp_data
);

    ata_pkg::cell_port_t  cell_port;
    ata_pkg::stamp_t      stamp_rdata;
    ata_pkg::stamp_t      accum_rdata;
    ata_pkg::rsp_t        rsp_next;
    logic                 rsp_load;
    logic                 out_free;
    logic                 suspended;
    logic                 out_valid_reg;
    ata_pkg::rsp_t        out_data_reg;

    // Start stamp table.
    ata_cell_ram u_stamp_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (cell_port.rd_en),
        .we    (cell_port.stamp_we),
        .addr  (cell_port.addr),
        .wdata (cell_port.stamp_wdata),
        .rdata (stamp_rdata)
    );

    // Accumulated time table.
    ata_cell_ram u_accum_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (cell_port.rd_en),
        .we    (cell_port.accum_we),
        .addr  (cell_port.addr),
        .wdata (cell_port.accum_wdata),
        .rdata (accum_rdata)
    );

    // Decoder and read-modify-write sequencer.
    ata_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_data    (req_data),
        .req_stall   (req_stall),
        .out_free    (out_free),
        .cell_port   (cell_port),
        .stamp_rdata (stamp_rdata),
        .accum_rdata (accum_rdata),
        .rsp_load    (rsp_load),
        .rsp_next    (rsp_next),
        .suspended   (suspended)
    );

    // Output register; it can take a new response when empty or being taken.
    assign out_free = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // An accepted request holds off the next one for its update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted during a cell update");

    // Only a successful read returns a nonzero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.read_value != '0) |-> rsp_data.status == ata_pkg::STATUS_DONE)
        else $error("nonzero read value with a failing status");

    // Measuring stays suspended once boot stop has been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(suspended) |-> suspended)
        else $error("suspended flag cleared without reset");

    // A table write happens only in the cycle the response is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_port.stamp_we || cell_port.accum_we |-> rsp_load)
        else $error("table write outside a response load");

endmodule
